// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of the header walker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define EHW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check a property on every clock edge, reset included.
`define EHW_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hdl/ehw_pkg.sv =====
// Package of the IPv6 extension header walker: sizes, codes and the result record.
package ehw_pkg;

    // Walk limits
    localparam int MAX_HOPS    = 8;
    localparam int OFFSET_BITS = 16;
    localparam int POS_W       = OFFSET_BITS + 1;
    localparam int HOP_W       = $clog2(MAX_HOPS + 1);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(1) << OFFSET_BITS;

    // Fixed header layout
    localparam logic [3:0]  IP_VERSION   = 4'd6;
    localparam int          BASE_LEN     = 40;
    localparam int          NH_FIELD_POS = 6;
    localparam int          ADDR_FIRST   = 8;
    localparam int          EXT_MIN_LEN  = 8;

    // Next header values
    localparam logic [7:0] NH_HOPOPT  = 8'd0;
    localparam logic [7:0] NH_TCP     = 8'd6;
    localparam logic [7:0] NH_UDP     = 8'd17;
    localparam logic [7:0] NH_ROUTING = 8'd43;
    localparam logic [7:0] NH_FRAG    = 8'd44;
    localparam logic [7:0] NH_AH      = 8'd51;
    localparam logic [7:0] NH_ICMP6   = 8'd58;
    localparam logic [7:0] NH_DSTOPT  = 8'd60;

    // Walk outcome codes
    localparam logic [1:0] WALK_BUSY = 2'd0;
    localparam logic [1:0] WALK_L4   = 2'd1;
    localparam logic [1:0] WALK_FRAG = 2'd2;
    localparam logic [1:0] WALK_BAD  = 2'd3;

    // Kind of header being parsed
    localparam logic [1:0] KIND_BASE = 2'd0;
    localparam logic [1:0] KIND_EXT  = 2'd1;
    localparam logic [1:0] KIND_FRAG = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_L4   = 2'd0;
    localparam logic [1:0] STAT_FRAG = 2'd1;
    localparam logic [1:0] STAT_BAD  = 2'd2;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  l4_proto;
        logic [15:0] l4_offset;
        logic [15:0] chain_len;
        logic [15:0] patch_offset;
        logic [15:0] frag_offset;
        logic        more_fragments;
        logic [31:0] frag_id;
        logic [63:0] src_addr_hi;
        logic [63:0] src_addr_lo;
        logic [63:0] dst_addr_hi;
        logic [63:0] dst_addr_lo;
    } t_result;

endpackage

// ===== hdl/ehw_intf.sv =====
// Channel interfaces of the header walker: packet bytes in, one result per packet out.
interface ehw_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ehw_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  l4_proto;
    logic [15:0] l4_offset;
    logic [15:0] chain_len;
    logic [15:0] patch_offset;
    logic [15:0] frag_offset;
    logic        more_fragments;
    logic [31:0] frag_id;
    logic [63:0] src_addr_hi;
    logic [63:0] src_addr_lo;
    logic [63:0] dst_addr_hi;
    logic [63:0] dst_addr_lo;

    modport source (
        output valid, input ready,
        output status, output l4_proto, output l4_offset, output chain_len,
        output patch_offset, output frag_offset, output more_fragments, output frag_id,
        output src_addr_hi, output src_addr_lo, output dst_addr_hi, output dst_addr_lo
    );
    modport sink (
        input valid, output ready,
        input status, input l4_proto, input l4_offset, input chain_len,
        input patch_offset, input frag_offset, input more_fragments, input frag_id,
        input src_addr_hi, input src_addr_lo, input dst_addr_hi, input dst_addr_lo
    );
endinterface

// ===== hdl/ehw_walk.sv =====
// Byte input register and per-byte header chain walk state of the header walker.
module ehw_walk (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ehw_byte_if.sink          i_byte,
    input  logic              i_res_free,
    output logic              o_push,
    output ehw_pkg::t_result  o_res
);
    import ehw_pkg::*;

    // Input register
    logic             r_in_vld;
    logic [7:0]       r_in_data;
    logic             r_in_last;
    logic             adv;

    // Walk control state
    logic [POS_W-1:0]       r_pos,       n_pos;
    logic [7:0]             r_cur_nh,    n_cur_nh;
    logic [OFFSET_BITS-1:0] r_hdr_start, n_hdr_start;
    logic [POS_W-1:0]       r_hdr_end,   n_hdr_end;
    logic [OFFSET_BITS-1:0] r_prev_pos,  n_prev_pos;
    logic [HOP_W-1:0]       r_hops,      n_hops;
    logic [1:0]             r_outcome,   n_outcome;
    logic [1:0]             r_kind,      n_kind;

    // Captured payload
    logic [63:0]            r_addr [4];
    logic [63:0]            n_addr [4];
    logic [15:0]            r_frag_word, n_frag_word;
    logic [31:0]            r_ident,     n_ident;
    logic [7:0]             r_proto,     n_proto;
    logic [OFFSET_BITS-1:0] r_res_off,   n_res_off;

    // Per-byte helpers
    logic [7:0]             b;
    logic                   active;
    logic [POS_W-1:0]       pn;
    logic [OFFSET_BITS-1:0] rel;
    logic [11:0]            hlen;
    logic [1:0]             addr_sel;
    logic                   addr_hit;
    logic [7:0]             nh;
    logic                   len_bad;
    logic [1:0]             status;

    // Advance the input register when its byte needs no result slot or one is free
    assign adv          = r_in_vld && (!r_in_last || i_res_free);
    assign i_byte.ready = !r_in_vld || adv;
    assign o_push       = adv && r_in_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_byte.valid && i_byte.ready) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_data <= i_byte.data_byte;
            r_in_last <= i_byte.last_byte;
        end
    end

    assign b        = r_in_data;
    assign active   = !r_pos[POS_W-1];
    assign pn       = r_pos + POS_W'(1);
    assign rel      = r_pos[OFFSET_BITS-1:0] - r_hdr_start;
    assign addr_sel = r_pos[4:3] - 2'd1;
    assign addr_hit = (r_pos >= POS_W'(ADDR_FIRST)) && (r_pos < POS_W'(BASE_LEN));
    assign hlen     = (r_cur_nh == NH_AH) ? {1'b0, 9'(b) + 9'd2, 2'b00}
                                          : {9'(b) + 9'd1, 3'b000};

    // Take one byte, then decide on the next header when the current one ends
    always_comb begin
        n_pos       = r_pos;
        n_cur_nh    = r_cur_nh;
        n_hdr_start = r_hdr_start;
        n_hdr_end   = r_hdr_end;
        n_prev_pos  = r_prev_pos;
        n_hops      = r_hops;
        n_outcome   = r_outcome;
        n_kind      = r_kind;
        n_addr      = r_addr;
        n_frag_word = r_frag_word;
        n_ident     = r_ident;
        n_proto     = r_proto;
        n_res_off   = r_res_off;
        nh          = r_cur_nh;

        if (active) begin
            n_pos = pn;

            // Version nibble of the first byte
            if (r_pos == '0 && b[7:4] != IP_VERSION && r_outcome == WALK_BUSY) begin
                n_outcome = WALK_BAD;
            end
            if (r_pos == POS_W'(NH_FIELD_POS)) begin
                n_cur_nh = b;
            end

            // Shift address bytes into their words
            for (int k = 0; k < 4; k++) begin
                if (addr_hit && addr_sel == 2'(k)) begin
                    n_addr[k] = {r_addr[k][55:0], b};
                end
            end

            // Fields of the extension or fragment header in progress
            if (r_outcome == WALK_BUSY && r_kind != KIND_BASE &&
                r_pos[OFFSET_BITS-1:0] >= r_hdr_start) begin
                if (r_kind == KIND_EXT) begin
                    if (rel == '0) begin
                        n_proto = b;
                    end else if (rel == OFFSET_BITS'(1)) begin
                        n_hdr_end = POS_W'(r_hdr_start) + POS_W'(hlen);
                    end
                end else begin
                    if (rel == '0) begin
                        n_proto = b;
                    end else if (rel == OFFSET_BITS'(2) || rel == OFFSET_BITS'(3)) begin
                        n_frag_word = {r_frag_word[7:0], b};
                    end else if (rel >= OFFSET_BITS'(4) && rel <= OFFSET_BITS'(7)) begin
                        n_ident = {r_ident[23:0], b};
                    end
                end
            end

            // Header boundary reached
            if (r_outcome == WALK_BUSY && pn == r_hdr_end) begin
                if (r_kind == KIND_FRAG) begin
                    n_outcome = WALK_FRAG;
                    n_res_off = OFFSET_BITS'(pn);
                end else begin
                    if (r_kind == KIND_EXT) begin
                        n_prev_pos = r_hdr_start;
                        n_cur_nh   = n_proto;
                        nh         = n_proto;
                    end else begin
                        nh = n_cur_nh;
                    end
                    if (r_hops >= HOP_W'(MAX_HOPS)) begin
                        n_outcome = WALK_BAD;
                    end else if (nh inside {NH_TCP, NH_UDP, NH_ICMP6}) begin
                        n_outcome = WALK_L4;
                        n_proto   = nh;
                        n_res_off = OFFSET_BITS'(pn);
                    end else if (nh == NH_FRAG) begin
                        n_kind      = KIND_FRAG;
                        n_hdr_start = OFFSET_BITS'(pn);
                        n_hdr_end   = pn + POS_W'(EXT_MIN_LEN);
                    end else if (nh inside {NH_HOPOPT, NH_ROUTING, NH_DSTOPT, NH_AH}) begin
                        n_kind      = KIND_EXT;
                        n_hops      = r_hops + HOP_W'(1);
                        n_hdr_start = OFFSET_BITS'(pn);
                        n_hdr_end   = pn + POS_W'(EXT_MIN_LEN);
                    end else begin
                        n_outcome = WALK_BAD;
                    end
                end
            end
        end
    end

    // Classify the packet on its last byte
    assign len_bad = (n_pos >= POS_LIMIT - POS_W'(1)) || (n_pos < POS_W'(BASE_LEN));

    always_comb begin
        if (len_bad) begin
            status = STAT_BAD;
        end else begin
            case (n_outcome)
                WALK_L4:   status = STAT_L4;
                WALK_FRAG: status = STAT_FRAG;
                default:   status = STAT_BAD;
            endcase
        end
    end

    // Assemble the result, zero where the status does not use a field
    always_comb begin
        o_res        = '0;
        o_res.status = status;
        if (status != STAT_BAD) begin
            o_res.l4_proto    = n_proto;
            o_res.l4_offset   = 16'(n_res_off);
            o_res.src_addr_hi = n_addr[0];
            o_res.src_addr_lo = n_addr[1];
            o_res.dst_addr_hi = n_addr[2];
            o_res.dst_addr_lo = n_addr[3];
        end
        if (status == STAT_FRAG) begin
            o_res.chain_len      = 16'(n_hdr_start);
            o_res.patch_offset   = 16'(n_prev_pos);
            o_res.frag_offset    = {n_frag_word[15:3], 3'b000};
            o_res.more_fragments = n_frag_word[0];
            o_res.frag_id        = n_ident;
        end
    end

    // Control state: advance per byte, restart after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_cur_nh    <= '0;
            r_hdr_start <= OFFSET_BITS'(BASE_LEN);
            r_hdr_end   <= POS_W'(BASE_LEN);
            r_prev_pos  <= OFFSET_BITS'(NH_FIELD_POS);
            r_hops      <= '0;
            r_outcome   <= WALK_BUSY;
            r_kind      <= KIND_BASE;
        end else if (adv) begin
            if (r_in_last) begin
                r_pos       <= '0;
                r_cur_nh    <= '0;
                r_hdr_start <= OFFSET_BITS'(BASE_LEN);
                r_hdr_end   <= POS_W'(BASE_LEN);
                r_prev_pos  <= OFFSET_BITS'(NH_FIELD_POS);
                r_hops      <= '0;
                r_outcome   <= WALK_BUSY;
                r_kind      <= KIND_BASE;
            end else begin
                r_pos       <= n_pos;
                r_cur_nh    <= n_cur_nh;
                r_hdr_start <= n_hdr_start;
                r_hdr_end   <= n_hdr_end;
                r_prev_pos  <= n_prev_pos;
                r_hops      <= n_hops;
                r_outcome   <= n_outcome;
                r_kind      <= n_kind;
            end
        end
    end

    // Payload captures are fully rewritten before any result uses them
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_addr      <= n_addr;
            r_frag_word <= n_frag_word;
            r_ident     <= n_ident;
            r_proto     <= n_proto;
            r_res_off   <= n_res_off;
        end
    end

endmodule

// ===== hdl/ehw_result.sv =====
// Result register of the header walker, driving the result channel.
module ehw_result (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ehw_pkg::t_result  i_res,
    output logic              o_free,
    ehw_res_if.source         o_res
);
    import ehw_pkg::*;

    logic    r_vld;
    t_result r_res;

    // Slot frees when empty or when the held result transfers this cycle
    assign o_free = !r_vld || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_push) begin
            r_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_res <= i_res;
        end
    end

    // Drive the channel from the held result
    assign o_res.valid          = r_vld;
    assign o_res.status         = r_res.status;
    assign o_res.l4_proto       = r_res.l4_proto;
    assign o_res.l4_offset      = r_res.l4_offset;
    assign o_res.chain_len      = r_res.chain_len;
    assign o_res.patch_offset   = r_res.patch_offset;
    assign o_res.frag_offset    = r_res.frag_offset;
    assign o_res.more_fragments = r_res.more_fragments;
    assign o_res.frag_id        = r_res.frag_id;
    assign o_res.src_addr_hi    = r_res.src_addr_hi;
    assign o_res.src_addr_lo    = r_res.src_addr_lo;
    assign o_res.dst_addr_hi    = r_res.dst_addr_hi;
    assign o_res.dst_addr_lo    = r_res.dst_addr_lo;

endmodule

// ===== hdl/ipv6_extension_header_walker_core.sv =====
// Top level of the IPv6 extension header walker.
//
// i_byte carries one packet byte per transfer in wire order, last_byte set on
// the final byte. o_res carries one result per packet: status 0 when TCP, UDP
// or ICMPv6 is reached, 1 when a fragment header is found, 2 when the packet
// is malformed, short, truncated, of unknown chain, of eight or more extension
// headers or 65535 bytes or longer. Addresses come with status 0 and 1.
// Throughput: one byte per cycle across packet boundaries while the result
// slot is free; a byte goes through an input register and the walk logic.
// The last byte goes through the input register into the result register.
// A stalled result holds in the output register; bytes keep flowing until a
// second last byte reaches the walk stage, which then waits for the slot.
// Reset (i_rst_n low at a clock edge) drops any held byte and result and
// restarts the walk at the first byte of a packet; after each last byte the
// walk restarts by itself.
module ipv6_extension_header_walker_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ehw_byte_if.sink   i_byte,
    ehw_res_if.source  o_res
);
    import ehw_pkg::*;

    logic    push;
    logic    res_free;
    t_result res;

    ehw_walk u_walk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte     (i_byte),
        .i_res_free (res_free),
        .o_push     (push),
        .o_res      (res)
    );

    ehw_result u_result (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (res),
        .o_free  (res_free),
        .o_res   (o_res)
    );

endmodule

// ===== hdl/ehw_checker.sv =====
// Port-level checks on the header walker result channel, bound to the top level.
`include "assert_macros.svh"

module ehw_props (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_status,
    input logic [7:0]  i_l4_proto,
    input logic [15:0] i_l4_offset,
    input logic [15:0] i_chain_len,
    input logic [15:0] i_patch_offset,
    input logic [31:0] i_frag_id,
    input logic [63:0] i_src_addr_hi
);
    import ehw_pkg::*;

    // No result survives reset
    `EHW_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> !i_out_valid, "result valid after reset")

    // Stalled result holds
    `EHW_ASSERT(a_stall_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status) && $stable(i_l4_offset) && $stable(i_src_addr_hi), "stalled result changed")

    // A malformed packet reports nothing else
    `EHW_ASSERT(a_bad_zero, i_out_valid && i_status == STAT_BAD |-> i_l4_proto == 8'd0 && i_l4_offset == 16'd0 && i_src_addr_hi == 64'd0 && i_frag_id == 32'd0, "malformed result carries data")

    // Fragment header geometry
    `EHW_ASSERT(a_frag_geom, i_out_valid && i_status == STAT_FRAG |-> i_l4_offset == i_chain_len + 16'd8 && i_patch_offset < i_chain_len, "fragment offsets inconsistent")

    // Transport header lies past the base header
    `EHW_ASSERT(a_l4_offset, i_out_valid && i_status == STAT_L4 |-> i_l4_offset >= 16'd40 && i_chain_len == 16'd0, "transport offset inconsistent")

endmodule

bind ipv6_extension_header_walker_core ehw_props u_ehw_props (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_status       (o_res.status),
    .i_l4_proto     (o_res.l4_proto),
    .i_l4_offset    (o_res.l4_offset),
    .i_chain_len    (o_res.chain_len),
    .i_patch_offset (o_res.patch_offset),
    .i_frag_id      (o_res.frag_id),
    .i_src_addr_hi  (o_res.src_addr_hi)
);
